/* rtl/fcfp_pkg.sv */
package fcfp_pkg;

    localparam int unsigned FRAME_LENGTH = 9;
    localparam int unsigned POS_W = 4;
    localparam int unsigned BODY_LEN = FRAME_LENGTH - 3;

    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LENGTH - 1);

    localparam logic [7:0] HEAD_FIRST = 8'h55;
    localparam logic [7:0] HEAD_SECOND = 8'hAA;
    localparam logic [7:0] TAIL_FIRST = 8'h66;
    localparam logic [7:0] TAIL_SECOND = 8'hBB;
    localparam logic [7:0] DUTY_LIMIT = 8'hA0;
    localparam logic [7:0] DUTY_LOW_MASK = 8'h0F;
    localparam logic [6:0] FULL_PERCENT = 7'd100;
    localparam logic [7:0] PERCENT_STEP = 8'd10;

    // Division by 100 is a multiply by ceil(2^30 / 100), exact for
    // dividends below 2^23.
    localparam int unsigned RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_K = 24'd10737419;
    localparam int unsigned SCALED_W = 40;
    localparam int unsigned PRODUCT_W = SCALED_W + 7;

    localparam int unsigned OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        CFG_COMMAND_TYPE = 2'd0,
        CFG_FAN_ON_CODE  = 2'd1,
        CFG_DUTY_OFFSET  = 2'd2,
        CFG_PWM_PERIOD   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_ON         = 2'd0,
        STATUS_FORCED_OFF = 2'd1,
        STATUS_BAD_TAIL   = 2'd2,
        STATUS_OTHER_TYPE = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]          command_type;
        logic [7:0]          fan_on_code;
        logic [6:0]          duty_offset;
        logic [15:0]         pwm_period;
        logic [SCALED_W-1:0] period_scaled;
    } cfg_t;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;

    localparam cfg_t CFG_RESET = '{
        command_type:  8'd1,
        fan_on_code:   8'd1,
        duty_offset:   7'd5,
        pwm_period:    PERIOD_RESET,
        period_scaled: {24'b0, PERIOD_RESET} * {16'b0, RECIP_K}
    };

    typedef struct packed {
        status_t     status;
        logic        fan_on;
        logic [7:0]  duty_kept;
        logic [7:0]  clear_flags;
        logic [15:0] compare;
    } frame_result_t;

endpackage

/* rtl/fan_command_frame_parser.sv */
// Fan command frame parser. Bytes from the host link enter on s_axis, one per
// clock when the result side is not stalled. The parser hunts for the header
// 0x55 0xAA (a repeated 0x55 restarts the header), collects a 9-byte frame and
// gives one status item on m_axis per completed frame, none for other bytes.
// A control frame with a good tail sets the fan switch, the duty code and the
// PWM compare, which is (10 * duty high nibble + offset, capped at 100) percent
// of the PWM period. Each byte is held in the input register and decoded in one
// pass into the result register, which holds the status item after the last
// frame byte; one byte is taken every cycle unless the input stalls. The result
// register holds a waiting item while the next bytes are taken; only a frame
// end that meets a still-waiting result stalls the input. The user must write
// registers through cfg only while the block is idle (the block does not
// enforce it): 0 command type, 1 fan-on code, 2 duty offset, 3 PWM period.
module fan_command_frame_parser
    import fcfp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] frame_status, [2] fan_enabled, [10:3] duty_code_kept,
    // [18:11] clear_request, [34:19] pwm_compare, [39:35] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       body_reg [BODY_LEN];
    logic             fan_on_reg;
    logic [15:0]      compare_reg;
    logic             out_valid_reg;
    frame_result_t    out_reg;
    frame_result_t    result;
    logic             frame_end;
    logic             advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_COMMAND_TYPE: cfg_reg.command_type <= cfg_data[7:0];
                CFG_FAN_ON_CODE:  cfg_reg.fan_on_code <= cfg_data[7:0];
                CFG_DUTY_OFFSET:  cfg_reg.duty_offset <= cfg_data[6:0];
                CFG_PWM_PERIOD: begin
                    cfg_reg.pwm_period <= cfg_data;
                    cfg_reg.period_scaled <= {24'b0, cfg_data} * {16'b0, RECIP_K};
                end
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign frame_end = (pos_reg == POS_LAST);
    assign advance = in_valid_reg && (!frame_end || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            byte_reg <= s_axis_tdata;
        end
    end

    always_comb begin
        pos_next = POS_HUNT;
        case (pos_reg)
            POS_HUNT: begin
                pos_next = (byte_reg == HEAD_FIRST) ? POS_SECOND : POS_HUNT;
            end
            POS_SECOND: begin
                if (byte_reg == HEAD_SECOND) begin
                    pos_next = pos_reg + POS_W'(1);
                end else if (byte_reg == HEAD_FIRST) begin
                    pos_next = POS_SECOND;
                end else begin
                    pos_next = POS_HUNT;
                end
            end
            default: begin
                pos_next = (pos_reg < POS_LAST) ? pos_reg + POS_W'(1) : POS_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
        end else if (advance) begin
            pos_reg <= pos_next;
        end
    end

    // Frame body shift line; at the frame end tap 0 holds the first tail byte
    // and the last tap holds the type byte.
    always_ff @(posedge aclk) begin
        if (advance) begin
            body_reg[0] <= byte_reg;
            for (int i = 1; i < BODY_LEN; i++) begin
                body_reg[i] <= body_reg[i-1];
            end
        end
    end

    fcfp_frame_decode u_decode (
        .cfg         (cfg_reg),
        .type_byte   (body_reg[5]),
        .switch_byte (body_reg[4]),
        .duty_byte   (body_reg[3]),
        .clear_byte  (body_reg[2]),
        .tail_first  (body_reg[0]),
        .tail_second (byte_reg),
        .fan_on_cur  (fan_on_reg),
        .compare_cur (compare_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fan_on_reg <= 1'b0;
            compare_reg <= 16'd0;
            out_valid_reg <= 1'b0;
        end else if (advance && frame_end) begin
            fan_on_reg <= result.fan_on;
            compare_reg <= result.compare;
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame_end) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {5'b0, out_reg.compare, out_reg.clear_flags, out_reg.duty_kept,
                           out_reg.fan_on, out_reg.status};

    assert property (@(posedge aclk) disable iff (!aresetn)
        !fan_on_reg |-> (compare_reg == 16'd0))
        else $error("PWM compare is nonzero while the fan is off");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("Frame position ran past the frame end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.status == STATUS_FORCED_OFF)) |->
            (!out_reg.fan_on && (out_reg.compare == 16'd0) && (out_reg.duty_kept == 8'd0)))
        else $error("Forced-off item reports a running fan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && frame_end) |=> (out_valid_reg && (fan_on_reg == out_reg.fan_on)))
        else $error("Fan state and reported item disagree after a frame end");

endmodule

/* rtl/fcfp_frame_decode.sv */
module fcfp_frame_decode
    import fcfp_pkg::*;
(
    input  cfg_t          cfg,
    input  logic [7:0]    type_byte,
    input  logic [7:0]    switch_byte,
    input  logic [7:0]    duty_byte,
    input  logic [7:0]    clear_byte,
    input  logic [7:0]    tail_first,
    input  logic [7:0]    tail_second,
    input  logic          fan_on_cur,
    input  logic [15:0]   compare_cur,
    output frame_result_t result
);

    logic                 tail_ok;
    logic                 duty_ok;
    logic [7:0]           tens;
    logic [8:0]           percent_sum;
    logic [6:0]           percent;
    logic [PRODUCT_W-1:0] product;
    logic [16:0]          quotient;
    logic [15:0]          compare;

    assign tail_ok = (tail_first == TAIL_FIRST) && (tail_second == TAIL_SECOND);
    assign duty_ok = (duty_byte <= DUTY_LIMIT) && ((duty_byte & DUTY_LOW_MASK) == 8'd0);

    assign tens = {4'b0, duty_byte[7:4]} * PERCENT_STEP;
    assign percent_sum = {1'b0, tens} + {2'b0, cfg.duty_offset};
    assign percent = (percent_sum > {2'b0, FULL_PERCENT}) ? FULL_PERCENT : percent_sum[6:0];

    // The period was already scaled by the reciprocal of 100 when written.
    assign product = {{SCALED_W{1'b0}}, percent} * {7'b0, cfg.period_scaled};
    assign quotient = product[RECIP_SHIFT+16:RECIP_SHIFT];
    assign compare = (quotient > {1'b0, cfg.pwm_period}) ? cfg.pwm_period : quotient[15:0];

    always_comb begin
        result.status = STATUS_BAD_TAIL;
        result.fan_on = fan_on_cur;
        result.duty_kept = 8'd0;
        result.clear_flags = 8'd0;
        result.compare = compare_cur;
        if (!tail_ok) begin
            result.status = STATUS_BAD_TAIL;
        end else if (type_byte != cfg.command_type) begin
            result.status = STATUS_OTHER_TYPE;
        end else begin
            result.clear_flags = clear_byte;
            if ((switch_byte == cfg.fan_on_code) && duty_ok) begin
                result.status = STATUS_ON;
                result.fan_on = 1'b1;
                result.duty_kept = duty_byte;
                result.compare = compare;
            end else begin
                result.status = STATUS_FORCED_OFF;
                result.fan_on = 1'b0;
                result.compare = 16'd0;
            end
        end
    end

endmodule

/* tb/fan_command_frame_parser_tb.sv */
`timescale 1ns / 100ps

module fan_command_frame_parser_tb;
    import fcfp_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_BYTES = 320;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    class fan_frame_scoreboard;
        logic [7:0] command_type;
        logic [7:0] on_code;
        logic [6:0] duty_offset;
        logic [15:0] period;

        logic [3:0] position;
        logic [7:0] frame_bytes[FRAME_LENGTH];
        logic fan_on;
        logic [15:0] compare;

        frame_result_t pending_status[$];
        int errors;
        int bytes_taken;
        int frames_checked;
        int status_seen[4];

        function new();
            command_type = 8'd1;
            on_code = 8'd1;
            duty_offset = 7'd5;
            period = 16'd1000;
            position = POS_HUNT;
            fan_on = 1'b0;
            compare = 16'd0;
            errors = 0;
            bytes_taken = 0;
            frames_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void apply_register(cfg_index_t idx, logic [15:0] value);
            case (idx)
                CFG_COMMAND_TYPE: command_type = value[7:0];
                CFG_FAN_ON_CODE: on_code = value[7:0];
                CFG_DUTY_OFFSET: duty_offset = value[6:0];
                CFG_PWM_PERIOD: period = value;
                default: ;
            endcase
        endfunction

        function logic [15:0] compare_for_duty(logic [7:0] duty);
            int unsigned pct;
            int unsigned cmp;
            pct = int'(duty[7:4]) * 10 + int'(duty_offset);
            if (pct > 100) pct = 100;
            cmp = (pct * int'(period)) / 100;
            if (cmp > int'(period)) cmp = int'(period);
            return cmp[15:0];
        endfunction

        function void take_byte(logic [7:0] b);
            frame_result_t res;
            logic [7:0] duty;
            bytes_taken++;
            if (position == POS_HUNT) begin
                if (b == HEAD_FIRST) begin
                    frame_bytes[0] = b;
                    position = POS_SECOND;
                end
                return;
            end
            if (position == POS_SECOND) begin
                if (b == HEAD_SECOND) begin
                    frame_bytes[1] = b;
                    position = 4'd2;
                end else if (b != HEAD_FIRST) begin
                    position = POS_HUNT;
                end
                return;
            end
            frame_bytes[position] = b;
            if (position != POS_LAST) begin
                position++;
                return;
            end
            position = POS_HUNT;
            res.duty_kept = 8'd0;
            res.clear_flags = 8'd0;
            if (frame_bytes[7] != TAIL_FIRST || frame_bytes[8] != TAIL_SECOND) begin
                res.status = STATUS_BAD_TAIL;
            end else if (frame_bytes[2] != command_type) begin
                res.status = STATUS_OTHER_TYPE;
            end else begin
                duty = frame_bytes[4];
                res.clear_flags = frame_bytes[5];
                if (frame_bytes[3] != on_code || duty > DUTY_LIMIT
                        || (duty & DUTY_LOW_MASK) != 8'd0) begin
                    res.status = STATUS_FORCED_OFF;
                    fan_on = 1'b0;
                    compare = 16'd0;
                end else begin
                    res.status = STATUS_ON;
                    fan_on = 1'b1;
                    compare = compare_for_duty(duty);
                    res.duty_kept = duty;
                end
            end
            res.fan_on = fan_on;
            res.compare = compare;
            pending_status.push_back(res);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 20) $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_status(logic [OUT_TDATA_W-1:0] data);
            frame_result_t want;
            if (pending_status.size() == 0) begin
                report_mismatch($sformatf("unexpected status item %h", data));
                return;
            end
            want = pending_status.pop_front();
            frames_checked++;
            status_seen[want.status]++;
            if (data[1:0] != want.status)
                report_mismatch($sformatf("frame_status %0d, expected %0d",
                    data[1:0], want.status));
            if (data[2] != want.fan_on)
                report_mismatch($sformatf("fan_enabled %0d, expected %0d",
                    data[2], want.fan_on));
            if (data[10:3] != want.duty_kept)
                report_mismatch($sformatf("duty_code_kept %h, expected %h",
                    data[10:3], want.duty_kept));
            if (data[18:11] != want.clear_flags)
                report_mismatch($sformatf("clear_request %h, expected %h",
                    data[18:11], want.clear_flags));
            if (data[34:19] != want.compare)
                report_mismatch($sformatf("pwm_compare %0d, expected %0d",
                    data[34:19], want.compare));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    fan_frame_scoreboard sb = new();
    idle_mode_t idle_mode = IDLE_NONE;
    bit hold_request = 1'b0;
    logic [7:0] rx_stream[$];

    fan_command_frame_parser dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 88;
            IDLE_BOTH: return $urandom_range(99) < 27;
            default: return 1'b0;
        endcase
    endfunction

    function bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99) < 88;
            IDLE_BOTH: return $urandom_range(99) < 27;
            default: return 1'b0;
        endcase
    endfunction

    always begin : status_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !receiver_stalls();
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 60 && sender_idles()) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        sb.take_byte(b);
        @(negedge aclk);
    endtask

    task automatic drive_stream();
        while (rx_stream.size() > 0) send_byte(rx_stream.pop_front());
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_status.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.apply_register(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_all(logic [7:0] ctype, logic [7:0] on_code, logic [6:0] offset,
            logic [15:0] period);
        wait_drained();
        write_register(CFG_COMMAND_TYPE, {8'd0, ctype});
        write_register(CFG_FAN_ON_CODE, {8'd0, on_code});
        write_register(CFG_DUTY_OFFSET, {9'd0, offset});
        write_register(CFG_PWM_PERIOD, period);
    endtask

    task automatic push_frame(logic [7:0] ctype, logic [7:0] sw, logic [7:0] duty,
            logic [7:0] clear, logic [7:0] t1, logic [7:0] t2);
        rx_stream.push_back(HEAD_FIRST);
        rx_stream.push_back(HEAD_SECOND);
        rx_stream.push_back(ctype);
        rx_stream.push_back(sw);
        rx_stream.push_back(duty);
        rx_stream.push_back(clear);
        rx_stream.push_back(8'($urandom));
        rx_stream.push_back(t1);
        rx_stream.push_back(t2);
    endtask

    task automatic push_random_traffic(int count);
        int pick;
        int n;
        logic [7:0] ctype;
        logic [7:0] sw;
        logic [7:0] duty;
        logic [7:0] t1;
        logic [7:0] t2;
        while (rx_stream.size() < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                n = $urandom_range(4, 1);
                repeat (n) rx_stream.push_back(8'($urandom));
            end else if (pick < 13) begin
                rx_stream.push_back(HEAD_FIRST);
                if ($urandom_range(1)) rx_stream.push_back(HEAD_FIRST);
                rx_stream.push_back(HEAD_SECOND);
                n = $urandom_range(6, 1);
                repeat (n) rx_stream.push_back(8'($urandom));
            end else begin
                ctype = ($urandom_range(9) < 7) ? sb.command_type : 8'($urandom);
                sw = ($urandom_range(9) < 6) ? sb.on_code : 8'($urandom);
                pick = $urandom_range(9);
                if (pick < 6) duty = {4'($urandom_range(10)), 4'd0};
                else if (pick < 8) duty = {4'($urandom_range(15, 11)), 4'd0};
                else duty = 8'($urandom);
                t1 = TAIL_FIRST;
                t2 = TAIL_SECOND;
                pick = $urandom_range(19);
                if (pick == 0) t1 = 8'($urandom);
                else if (pick == 1) t2 = 8'($urandom);
                else if (pick == 2) begin
                    t1 = 8'($urandom);
                    t2 = 8'($urandom);
                end
                push_frame(ctype, sw, duty, 8'($urandom), t1, t2);
            end
        end
    endtask

    task automatic run_phase(idle_mode_t mode, int count);
        idle_mode = mode;
        push_random_traffic(count);
        drive_stream();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Header restarts, saturation, each forced-off cause, bad tail, other type.
        rx_stream = '{8'h55, 8'h13, 8'h55};
        push_frame(8'd1, 8'd1, 8'hA0, 8'hFF, TAIL_FIRST, TAIL_SECOND);
        push_frame(8'd1, 8'd1, 8'h00, 8'h00, TAIL_FIRST, TAIL_SECOND);
        push_frame(8'd1, 8'd1, 8'hA8, 8'h81, TAIL_FIRST, TAIL_SECOND);
        push_frame(8'd1, 8'd0, 8'h50, 8'h7E, TAIL_FIRST, TAIL_SECOND);
        push_frame(8'd1, 8'd1, 8'hB0, 8'h01, TAIL_FIRST, TAIL_SECOND);
        push_frame(8'd1, 8'd1, 8'h30, 8'h00, TAIL_FIRST, 8'hBA);
        push_frame(8'd2, 8'd1, 8'h30, 8'h00, TAIL_FIRST, TAIL_SECOND);
        idle_mode = IDLE_NONE;
        drive_stream();

        write_all(8'd0, 8'd255, 7'd0, 16'd1);
        run_phase(IDLE_SENDER, PHASE_BYTES);

        write_all(8'd255, 8'd0, 7'd100, 16'd65535);
        run_phase(IDLE_RECEIVER, PHASE_BYTES);

        write_all(8'($urandom), 8'($urandom), 7'd127, 16'd0);
        run_phase(IDLE_BOTH, PHASE_BYTES);

        write_all(8'($urandom), 8'($urandom), 7'($urandom_range(100)),
            16'($urandom_range(65535, 1)));
        hold_request = 1'b1;
        run_phase(IDLE_NONE, PHASE_BYTES);

        write_all(8'd1, 8'd1, 7'($urandom_range(100)), 16'($urandom_range(65535, 1)));
        run_phase(IDLE_BOTH, PHASE_BYTES);

        wait_drained();
        if (sb.pending_status.size() != 0)
            sb.report_mismatch("status items still expected at the end");
        $display("Sent %0d bytes over six register settings; checked %0d frame results.",
            sb.bytes_taken, sb.frames_checked);
        $display("Results by status: on %0d, forced off %0d, bad tail %0d, other type %0d.",
            sb.status_seen[STATUS_ON], sb.status_seen[STATUS_FORCED_OFF],
            sb.status_seen[STATUS_BAD_TAIL], sb.status_seen[STATUS_OTHER_TYPE]);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
